@@ design/sngt_pkg.sv @@
// Package for the single-level name table.
// Holds sizing constants, payload structs, command and status codes and the FSM state type.
// No dependencies.
`default_nettype none

package sngt_pkg;

  localparam int ENTRIES = 16;
  localparam int NAME_W  = 56;
  localparam int WORD_W  = 2 * NAME_W;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    ACT_CREATE = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_SEARCH = 2'd2,
    ACT_LIST   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    STAT_ADDED    = 3'd0,
    STAT_DUP      = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_REMOVED  = 3'd3,
    STAT_NOTFOUND = 3'd4,
    STAT_FOUND    = 3'd5,
    STAT_LISTED   = 3'd6,
    STAT_EMPTY    = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_LIST
  } state_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [NAME_W-1:0] name_front;
    logic [NAME_W-1:0] name_back;
  } in_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [NAME_W-1:0] entry_front;
    logic [NAME_W-1:0] entry_back;
    logic              last;
  } out_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [WORD_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } ram_req_t;

endpackage

`default_nettype wire

@@ design/sngt_ram.sv @@
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// Read data holds when no read is issued. No dependencies.
`default_nettype none

module sngt_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 112,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ design/sngt_ctrl.sv @@
// Command sequencer for the name table: scans, shifts and lists the stored names
// through the RAM port and drives the result register. Depends on sngt_pkg.
`default_nettype none

module sngt_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire sngt_pkg::in_t             in_data,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output sngt_pkg::out_t                 out_data,
  output sngt_pkg::ram_req_t             ram_req,
  input  wire logic [sngt_pkg::WORD_W-1:0] ram_rdata
);

  import sngt_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] pidx_r, pidx_nxt;
  logic             pend_r, pend_nxt;
  in_t              cmd_r, cmd_nxt;
  logic             out_valid_r;
  out_t             out_r, res;
  logic             load;
  logic             out_free;
  logic             issue_ok;
  logic             match;
  logic             is_last;
  logic [CNT_W-1:0] pidx_m1;

  assign out_free  = !out_valid_r || out_ready;
  assign issue_ok  = rd_ptr_r < count_r;
  assign match     = ram_rdata == {cmd_r.name_front, cmd_r.name_back};
  assign is_last   = CNT_W'(pidx_r + 1'b1) == count_r;
  assign pidx_m1   = pidx_r - 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      rd_ptr_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      pend_r   <= pend_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    pidx_r <= pidx_nxt;
    if (load) begin
      out_r <= res;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    rd_ptr_nxt = rd_ptr_r;
    pidx_nxt   = pidx_r;
    pend_nxt   = pend_r;
    cmd_nxt    = cmd_r;
    in_ready   = 1'b0;
    load       = 1'b0;
    res        = '0;
    res.last   = 1'b1;
    ram_req    = '0;
    ram_req.raddr = rd_ptr_r[IDX_W-1:0];
    ram_req.wdata = {cmd_r.name_front, cmd_r.name_back};

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_nxt    = in_data;
          rd_ptr_nxt = '0;
          pend_nxt   = 1'b0;
          state_nxt  = (in_data.action == ACT_LIST) ? ST_LIST : ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (pend_r && match && cmd_r.action == ACT_DELETE) begin
          rd_ptr_nxt = CNT_W'(pidx_r + 1'b1);
          pend_nxt   = 1'b0;
          state_nxt  = ST_SHIFT;
        end else if ((pend_r && match) || (!pend_r && !issue_ok)) begin
          if (out_free) begin
            load      = 1'b1;
            pend_nxt  = 1'b0;
            state_nxt = ST_IDLE;
            case (cmd_r.action)
              ACT_CREATE: begin
                if (pend_r) begin
                  res.status = STAT_DUP;
                end else if (count_r == CNT_W'(ENTRIES)) begin
                  res.status = STAT_FULL;
                end else begin
                  res.status    = STAT_ADDED;
                  ram_req.we    = 1'b1;
                  ram_req.waddr = count_r[IDX_W-1:0];
                  count_nxt     = count_r + 1'b1;
                end
              end
              ACT_SEARCH: res.status = pend_r ? STAT_FOUND : STAT_NOTFOUND;
              default:    res.status = STAT_NOTFOUND;
            endcase
          end
        end else begin
          pend_nxt = issue_ok;
          if (issue_ok) begin
            ram_req.re = 1'b1;
            pidx_nxt   = rd_ptr_r;
            rd_ptr_nxt = rd_ptr_r + 1'b1;
          end
        end
      end

      ST_SHIFT: begin
        if (pend_r) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = pidx_m1[IDX_W-1:0];
          ram_req.wdata = ram_rdata;
        end
        if (!pend_r && !issue_ok) begin
          if (out_free) begin
            load       = 1'b1;
            res.status = STAT_REMOVED;
            count_nxt  = count_r - 1'b1;
            state_nxt  = ST_IDLE;
          end
        end else begin
          pend_nxt = issue_ok;
          if (issue_ok) begin
            ram_req.re = 1'b1;
            pidx_nxt   = rd_ptr_r;
            rd_ptr_nxt = rd_ptr_r + 1'b1;
          end
        end
      end

      ST_LIST: begin
        if (pend_r) begin
          if (out_free) begin
            load            = 1'b1;
            res.status      = STAT_LISTED;
            res.entry_front = ram_rdata[WORD_W-1:NAME_W];
            res.entry_back  = ram_rdata[NAME_W-1:0];
            res.last        = is_last;
            if (is_last) begin
              pend_nxt  = 1'b0;
              state_nxt = ST_IDLE;
            end else begin
              pend_nxt = issue_ok;
              if (issue_ok) begin
                ram_req.re = 1'b1;
                pidx_nxt   = rd_ptr_r;
                rd_ptr_nxt = rd_ptr_r + 1'b1;
              end
            end
          end
        end else if (!issue_ok) begin
          if (out_free) begin
            load       = 1'b1;
            res.status = STAT_EMPTY;
            state_nxt  = ST_IDLE;
          end
        end else begin
          pend_nxt   = 1'b1;
          ram_req.re = 1'b1;
          pidx_nxt   = rd_ptr_r;
          rd_ptr_nxt = rd_ptr_r + 1'b1;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(ENTRIES))
    else $error("entry count exceeds table size");

  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.we |-> (state_r == ST_SCAN || state_r == ST_SHIFT))
    else $error("table write outside scan or shift");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r != ST_IDLE)
    else $error("accepted command did not start");

  a_list_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LIST && pend_r) |-> pidx_r < count_r)
    else $error("list read beyond stored entries");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != count_nxt) |-> load)
    else $error("entry count changed without a result");
`endif

endmodule

`default_nettype wire

@@ design/single_level_name_table.sv @@
// Top level of the single-level name table: command sequencer plus the name RAM.
// Depends on sngt_pkg, sngt_ram and sngt_ctrl.
//
// Usage: commands arrive on the in_ channel (valid/ready); each transfer carries an
// action and a 14-byte name split in two 56-bit halves. Results leave on the out_
// channel (valid/ready); create, delete and search give one result, list gives one
// result per stored entry (or one "empty" result), with last set on the final one.
// Names live in one RAM with registered read data; every command walks it one
// entry per cycle (list only while the receiver does not stall). Create and
// search stop early on a match; delete shifts the later entries down, starting
// where the scan stops.
// One command is in work at a time; a new one is accepted as soon as the sequencer
// is idle, even while the last result still waits in the output register.
// Reset empties the table at once (the entry count clears; RAM contents are not
// touched). When the receiver stalls, the sequencer holds its position and the
// pending result until the transfer completes.
`default_nettype none

module single_level_name_table (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire sngt_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output sngt_pkg::out_t      out_data
);

  import sngt_pkg::*;

  ram_req_t          ram_req;
  logic [WORD_W-1:0] ram_rdata;

  sngt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  sngt_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (WORD_W),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

@@ sim/name_table_scoreboard.sv @@
// Scoreboard package for the single-level name table testbench.
// Mirrors the ordered name table and checks each output transfer in order.
// Depends on sngt_pkg.
`timescale 1ns / 1ps

package name_table_tb_pkg;
  import sngt_pkg::*;

  class name_table_scoreboard;
    logic [NAME_W-1:0] held_front[ENTRIES];
    logic [NAME_W-1:0] held_back[ENTRIES];
    int held_count;
    out_t expected_q[$];
    int errors;

    function new();
      held_count = 0;
      errors = 0;
    endfunction

    function int locate(logic [NAME_W-1:0] front, logic [NAME_W-1:0] back);
      for (int i = 0; i < held_count; i++) begin
        if (held_front[i] == front && held_back[i] == back) return i;
      end
      return -1;
    endfunction

    function void push_result(status_t status, logic [NAME_W-1:0] front,
                              logic [NAME_W-1:0] back, logic last);
      out_t r;
      r.status      = status;
      r.entry_front = front;
      r.entry_back  = back;
      r.last        = last;
      expected_q.push_back(r);
    endfunction

    function void note_command(in_t cmd);
      int pos;
      pos = locate(cmd.name_front, cmd.name_back);
      case (action_t'(cmd.action))
        ACT_CREATE: begin
          if (pos >= 0) begin
            push_result(STAT_DUP, '0, '0, 1'b1);
          end else if (held_count >= ENTRIES) begin
            push_result(STAT_FULL, '0, '0, 1'b1);
          end else begin
            held_front[held_count] = cmd.name_front;
            held_back[held_count]  = cmd.name_back;
            held_count++;
            push_result(STAT_ADDED, '0, '0, 1'b1);
          end
        end
        ACT_DELETE: begin
          if (pos < 0) begin
            push_result(STAT_NOTFOUND, '0, '0, 1'b1);
          end else begin
            for (int i = pos; i + 1 < held_count; i++) begin
              held_front[i] = held_front[i+1];
              held_back[i]  = held_back[i+1];
            end
            held_count--;
            push_result(STAT_REMOVED, '0, '0, 1'b1);
          end
        end
        ACT_SEARCH: begin
          push_result((pos >= 0) ? STAT_FOUND : STAT_NOTFOUND, '0, '0, 1'b1);
        end
        default: begin
          if (held_count == 0) begin
            push_result(STAT_EMPTY, '0, '0, 1'b1);
          end else begin
            for (int i = 0; i < held_count; i++) begin
              push_result(STAT_LISTED, held_front[i], held_back[i], i + 1 == held_count);
            end
          end
        end
      endcase
    endfunction

    task report(string what);
      $display("%0t: mismatch: %s", $time, what);
      errors++;
    endtask

    task check_result(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result, status %0d", got.status));
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.entry_front !== want.entry_front)
        report($sformatf("entry_front %h, expected %h", got.entry_front, want.entry_front));
      if (got.entry_back !== want.entry_back)
        report($sformatf("entry_back %h, expected %h", got.entry_back, want.entry_back));
      if (got.last !== want.last)
        report($sformatf("last %b, expected %b", got.last, want.last));
    endtask

    function int outstanding();
      return expected_q.size();
    endfunction
  endclass

endpackage

@@ sim/single_level_name_table_tb.sv @@
// Top-level testbench for the single-level name table.
// Drives directed and random commands with random idling on both channels.
// Depends on sngt_pkg, name_table_tb_pkg and the single_level_name_table RTL.
`timescale 1ns / 1ps

module single_level_name_table_tb;
  import sngt_pkg::*;
  import name_table_tb_pkg::*;

  localparam int LIMIT        = 200000;
  localparam int SETTLE_CYCLES = 2 * ENTRIES + 12;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  bit calm = 1'b0;
  int stall_left = 0;
  int cycle_count = 0;
  logic [NAME_W-1:0] past_front[$];
  logic [NAME_W-1:0] past_back[$];
  name_table_scoreboard table_sb = new();

  single_level_name_table u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) table_sb.check_result(out_data);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [NAME_W-1:0] rand_half();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[NAME_W-1:0];
  endfunction

  task automatic send(action_t act, logic [NAME_W-1:0] front, logic [NAME_W-1:0] back);
    in_t cmd;
    cmd.action     = act;
    cmd.name_front = front;
    cmd.name_back  = back;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    do @(posedge clk); while (!in_ready);
    table_sb.note_command(cmd);
    if (act == ACT_CREATE) begin
      past_front.push_back(front);
      past_back.push_back(back);
      if (past_front.size() > 32) begin
        void'(past_front.pop_front());
        void'(past_back.pop_front());
      end
    end
  endtask

  // Valid is dropped first so that the held command is not taken twice.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (table_sb.outstanding() != 0);
  endtask

  task automatic pick_name(output logic [NAME_W-1:0] front, output logic [NAME_W-1:0] back);
    int mode;
    int k;
    mode = $urandom_range(0, 9);
    if (mode <= 3 && table_sb.held_count > 0) begin
      k = $urandom_range(0, table_sb.held_count - 1);
      front = table_sb.held_front[k];
      back  = table_sb.held_back[k];
    end else if (mode <= 5 && past_front.size() > 0) begin
      k = $urandom_range(0, past_front.size() - 1);
      front = past_front[k];
      back  = past_back[k];
    end else if (mode == 6 && table_sb.held_count > 0) begin
      k = $urandom_range(0, table_sb.held_count - 1);
      front = table_sb.held_front[k];
      back  = rand_half();
      if ($urandom_range(0, 1) == 1) begin
        front = rand_half();
        back  = table_sb.held_back[k];
      end
    end else if (mode == 7) begin
      front = ($urandom_range(0, 1) == 1) ? '1 : '0;
      back  = ($urandom_range(0, 1) == 1) ? '1 : '0;
    end else begin
      front = rand_half();
      back  = rand_half();
    end
  endtask

  task automatic random_mix(int n);
    action_t act;
    logic [NAME_W-1:0] f;
    logic [NAME_W-1:0] b;
    repeat (n) begin
      act = action_t'($urandom_range(0, 3));
      if ($urandom_range(0, 2) == 0) act = ACT_CREATE;
      pick_name(f, b);
      send(act, f, b);
    end
  endtask

  task automatic fill_table();
    int k;
    while (table_sb.held_count < ENTRIES) send(ACT_CREATE, rand_half(), rand_half());
    send(ACT_CREATE, rand_half(), rand_half());
    k = $urandom_range(0, ENTRIES - 1);
    send(ACT_CREATE, table_sb.held_front[k], table_sb.held_back[k]);
    send(ACT_SEARCH, table_sb.held_front[ENTRIES-1], table_sb.held_back[ENTRIES-1]);
    send(ACT_LIST, '0, '0);
    k = $urandom_range(1, ENTRIES - 2);
    send(ACT_DELETE, table_sb.held_front[k], table_sb.held_back[k]);
    send(ACT_DELETE, table_sb.held_front[0], table_sb.held_back[0]);
    k = table_sb.held_count - 1;
    send(ACT_DELETE, table_sb.held_front[k], table_sb.held_back[k]);
    send(ACT_LIST, '0, '0);
  endtask

  initial begin
    logic [NAME_W-1:0] alpha;
    int k;
    alpha = {"alpha", 16'h0000};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send(ACT_LIST, '0, '0);
    send(ACT_SEARCH, '0, '0);
    send(ACT_DELETE, '0, '0);
    send(ACT_CREATE, '0, '0);
    send(ACT_CREATE, '1, '1);
    send(ACT_CREATE, '0, '0);
    send(ACT_SEARCH, '0, '0);
    send(ACT_SEARCH, '0, 56'd1);
    send(ACT_SEARCH, '1, '0);
    send(ACT_CREATE, alpha, '0);
    send(ACT_LIST, '0, '0);
    send(ACT_DELETE, '0, '0);
    send(ACT_LIST, '0, '0);
    send(ACT_DELETE, '1, '1);
    send(ACT_DELETE, '0, '0);
    send(ACT_SEARCH, '0, '0);
    send(ACT_CREATE, '0, '0);
    send(ACT_LIST, '0, '0);
    send(ACT_DELETE, alpha, '0);
    send(ACT_DELETE, '0, '0);
    send(ACT_LIST, '0, '0);

    random_mix(20);
    fill_table();
    wait_idle();
    random_mix(40);
    fill_table();
    random_mix(30);

    calm = 1'b1;
    while (table_sb.held_count > 0) begin
      k = $urandom_range(0, table_sb.held_count - 1);
      send(ACT_DELETE, table_sb.held_front[k], table_sb.held_back[k]);
    end
    send(ACT_LIST, '0, '0);
    random_mix(8);

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (table_sb.errors == 0 && table_sb.outstanding() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/sngt_pkg.sv
design/sngt_ram.sv
design/sngt_ctrl.sv
design/single_level_name_table.sv
sim/name_table_scoreboard.sv
sim/single_level_name_table_tb.sv
